/* src/pds_pkg.sv */
// shared types and constants for the pll divider search
// no dependencies
package pds_pkg;

  localparam logic [23:0] REF_HZ     = 24'd14318181;
  localparam logic [13:0] REF_KHZ    = 14'd14318;
  localparam logic [13:0] FRAC_SCALE = 14'd10000;
  localparam logic [13:0] FRAC_HALF  = 14'd5000;
  localparam logic [13:0] KHZ_DIV    = 14'd1000;
  localparam logic [3:0]  N_MAX      = 4'd15;
  localparam logic [3:0]  N_MIN      = 4'd2;
  localparam logic [2:0]  D_MAX      = 3'd6;
  localparam logic [2:0]  OD_MAX     = 3'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KHZ,
    ST_LAUNCH_Q,
    ST_QDIV,
    ST_FDIV,
    ST_LAUNCH_M,
    ST_MDIV,
    ST_CDIV,
    ST_DONE
  } state_t;

endpackage

/* src/pds_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
// uses no package
module pds_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [13:0] divisor,
  input  logic [5:0]  steps,
  output logic        done,
  output logic [31:0] quotient,
  output logic [13:0] remainder
);

  logic [31:0] num;
  logic [13:0] den;
  logic [5:0]  cnt;
  logic        active;
  logic [14:0] partial;
  logic        ge;

  // trial subtract of the next dividend bit
  assign partial = {remainder, num[31]};
  assign ge      = partial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active    <= 1'b1;
        cnt       <= steps;
        num       <= dividend << (6'd32 - steps);
        den       <= divisor;
        remainder <= '0;
        quotient  <= '0;
      end else if (active) begin
        remainder <= ge ? 14'(partial - {1'b0, den}) : partial[13:0];
        quotient  <= {quotient[30:0], ge};
        num       <= num << 1;
        cnt       <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

/* src/pll_divider_search.sv */
// top level of the pll divider search: sequencer and best-candidate tracking
// depends on pds_pkg and pds_div
//
// Usage: a request carries request_hz on in_valid/in_ready; the result
// carries multiplier, input_divider, output_divider_exp, post_divider_exp,
// achieved_hz and setting_word on out_valid/out_ready.
// One request is handled at a time: in_ready is high only while idle.
// Sequence: the kHz scaling first, then per input divider N (15 down to 2)
// the quotient and fraction, then per exponent d (6 down to 0) the
// multiplier division plus the achieved-clock division when the multiplier
// is in range.
// All divisions go through one shared bit-serial divider, one bit a cycle.
// The result is held until out_ready; the next request is taken after it.
// Reset clears the last chosen m, n, od and pod to zero; when no candidate
// fits, those stored values are repeated and achieved_hz is zero.
module pll_divider_search
  import pds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [28:0] request_hz,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  multiplier,
  output logic [3:0]  input_divider,
  output logic [1:0]  output_divider_exp,
  output logic [1:0]  post_divider_exp,
  output logic [31:0] achieved_hz,
  output logic [13:0] setting_word
);

  state_t state, state_next;

  logic [28:0] req;
  logic [19:0] req_khz;
  logic [3:0]  n;
  logic [2:0]  d;
  logic [9:0]  q;
  logic [13:0] f;
  logic [7:0]  m_cand;
  logic        found;
  logic [31:0] best_diff;
  logic [31:0] achieved;
  logic [7:0]  last_m;
  logic [3:0]  last_n;
  logic [1:0]  last_od;
  logic [1:0]  last_pod;

  logic        div_start;
  logic [31:0] div_a;
  logic [13:0] div_b;
  logic [5:0]  div_steps;
  logic        div_done;
  logic [31:0] div_q;
  logic [13:0] div_r;

  logic [16:0] m_full;
  logic        m_ok;
  logic [31:0] clk_hz;
  logic [31:0] diff;
  logic [2:0]  pod;
  logic [22:0] r_prod;
  logic [27:0] frac_num;

  pds_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .steps     (div_steps),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // candidate arithmetic
  assign r_prod   = 23'(n * req_khz);
  assign frac_num = 28'(div_r * FRAC_SCALE);
  assign m_full   = 17'({7'd0, q} << d) + 17'(div_q[6:0])
                    + ((div_r > FRAC_HALF) ? 17'd1 : 17'd0);
  assign m_ok     = (m_full != 17'd0) && (m_full < 17'd256);
  assign clk_hz   = div_q >> d;
  assign diff     = (clk_hz >= {3'd0, req}) ? clk_hz - {3'd0, req}
                                             : {3'd0, req} - clk_hz;
  assign pod      = (d > OD_MAX) ? d - OD_MAX : 3'd0;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and divider launches
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_a      = '0;
    div_b      = KHZ_DIV;
    div_steps  = 6'd29;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          div_start  = 1'b1;
          div_a      = {3'd0, request_hz};
          state_next = ST_KHZ;
        end
      end
      ST_KHZ: begin
        if (div_done) state_next = ST_LAUNCH_Q;
      end
      ST_LAUNCH_Q: begin
        div_start  = 1'b1;
        div_a      = {9'd0, r_prod};
        div_b      = REF_KHZ;
        div_steps  = 6'd23;
        state_next = ST_QDIV;
      end
      ST_QDIV: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_a      = {4'd0, frac_num};
          div_b      = REF_KHZ;
          div_steps  = 6'd28;
          state_next = ST_FDIV;
        end
      end
      ST_FDIV: begin
        if (div_done) state_next = ST_LAUNCH_M;
      end
      ST_LAUNCH_M: begin
        div_start  = 1'b1;
        div_a      = {18'd0, f} << d;
        div_b      = FRAC_SCALE;
        div_steps  = 6'd20;
        state_next = ST_MDIV;
      end
      ST_MDIV: begin
        if (div_done) begin
          if (m_ok) begin
            div_start  = 1'b1;
            div_a      = 32'(REF_HZ * m_full[7:0]);
            div_b      = {10'd0, n};
            div_steps  = 6'd32;
            state_next = ST_CDIV;
          end else if (d != 3'd0) begin
            state_next = ST_LAUNCH_M;
          end else if (n != N_MIN) begin
            state_next = ST_LAUNCH_Q;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_CDIV: begin
        if (div_done) begin
          if (d != 3'd0) begin
            state_next = ST_LAUNCH_M;
          end else if (n != N_MIN) begin
            state_next = ST_LAUNCH_Q;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // search registers and best-candidate tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      found    <= 1'b0;
      last_m   <= '0;
      last_n   <= '0;
      last_od  <= '0;
      last_pod <= '0;
      achieved <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req      <= request_hz;
            found    <= 1'b0;
            achieved <= '0;
            n        <= N_MAX;
          end
        end
        ST_KHZ: begin
          if (div_done) req_khz <= div_q[19:0];
        end
        ST_QDIV: begin
          if (div_done) q <= div_q[9:0];
        end
        ST_FDIV: begin
          if (div_done) begin
            f <= div_q[13:0];
            d <= D_MAX;
          end
        end
        ST_MDIV: begin
          if (div_done) begin
            m_cand <= m_full[7:0];
            if (!m_ok) begin
              if (d != 3'd0) begin
                d <= d - 3'd1;
              end else begin
                n <= n - 4'd1;
              end
            end
          end
        end
        ST_CDIV: begin
          if (div_done) begin
            if (!found || diff < best_diff) begin
              found     <= 1'b1;
              best_diff <= diff;
              achieved  <= clk_hz;
              last_m    <= m_cand;
              last_n    <= n;
              last_pod  <= pod[1:0];
              last_od   <= 2'(d - pod);
            end
            if (d != 3'd0) begin
              d <= d - 3'd1;
            end else begin
              n <= n - 4'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // handshake and result fields
  assign in_ready           = (state == ST_IDLE);
  assign out_valid          = (state == ST_DONE);
  assign multiplier         = last_m;
  assign input_divider      = last_n;
  assign output_divider_exp = last_od;
  assign post_divider_exp   = last_pod;
  assign achieved_hz        = achieved;
  assign setting_word       = {last_od, last_n, last_m};

endmodule
